[design/iss_pkg.sv]
// ----------------------------------------------------------------------------
// iss_pkg
// Shared types, field constants and status codes of the signature scanner.
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int unsigned WordW = 32;

  typedef logic [WordW-1:0] word_t;

  // Primary opcodes (bits 31:26).
  localparam logic [5:0] OPC_STW  = 6'd36;
  localparam logic [5:0] OPC_STB  = 6'd38;
  localparam logic [5:0] OPC_LI   = 6'd14;
  localparam logic [5:0] OPC_B    = 6'd18;

  // Displacement / immediate values of the signature.
  localparam logic [15:0] STW_DISP = 16'h0014;
  localparam logic [15:0] STB_DISP = 16'h000c;
  localparam logic [15:0] LI_VALUE = 16'h0079;

  // AA=0, LK=1 for a relative branch-and-link.
  localparam logic [1:0] BL_AA_LK = 2'b01;

  typedef enum logic [1:0] {
    STATUS_FOUND    = 2'd0,
    STATUS_NONE     = 2'd1,
    STATUS_SEVERAL  = 2'd2,
    STATUS_NO_LINK  = 2'd3
  } status_t;

  // Per-word decode flags handed from the decoder to the scanner control.
  typedef struct packed {
    logic is_stw;
    logic is_li;
    logic is_stb;
    logic is_bl;
  } word_class_t;

endpackage

[design/iss_decode.sv]
// ----------------------------------------------------------------------------
// iss_decode
// Classifies one instruction word and forms the branch-and-link target.
// ----------------------------------------------------------------------------
module iss_decode (
  input  iss_pkg::word_t       word_address,
  input  iss_pkg::word_t       instruction_word,
  output iss_pkg::word_class_t word_class,
  output iss_pkg::word_t       link_target
);
  import iss_pkg::*;

  logic [5:0]  opc;
  logic [15:0] disp;
  word_t       offset;

  assign opc  = instruction_word[31:26];
  assign disp = instruction_word[15:0];

  assign word_class.is_stw = (opc == OPC_STW) && (disp == STW_DISP);
  assign word_class.is_li  = (opc == OPC_LI) && (instruction_word[20:16] == 5'd0)
                             && (disp == LI_VALUE);
  assign word_class.is_stb = (opc == OPC_STB) && (disp == STB_DISP);
  assign word_class.is_bl  = (opc == OPC_B) && (instruction_word[1:0] == BL_AA_LK);

  // Sign-extended 26-bit byte offset; sum wraps mod 2^32.
  assign offset      = {{6{instruction_word[25]}}, instruction_word[25:2], 2'b00};
  assign link_target = word_address + offset;

endmodule

[design/instruction_signature_scanner.sv]
// ----------------------------------------------------------------------------
// instruction_signature_scanner
// Streams a region of instruction words and reports the signature status.
// ----------------------------------------------------------------------------
// One instruction word with its byte address is taken per input transaction,
// in region order; the word flagged by last_word closes the region. The block
// looks for a three-word signature (store word with displacement 0x14, load
// immediate of 0x79 with ra zero, store byte with displacement 0xc) and, after
// the first signature, captures the target of the first later relative
// branch-and-link. Only the last word produces an output transaction:
// scan_status (found / none / several / no branch-and-link) and branch_target,
// which is zero unless the status is found. The block then restarts clean for
// the next region. Decode and the state update are combinational and sit
// between the input handshake and the state/result registers, so a word is
// accepted every cycle while the output register is empty or being drained.
// The output register holds one result; in_ready drops only while that result
// waits on out_ready. The window keeps decode flags of the two previous words
// rather than the raw words, which is all the signature compare needs.
module instruction_signature_scanner (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  iss_pkg::word_t      word_address,
  input  iss_pkg::word_t      instruction_word,
  input  logic                last_word,
  output logic                out_valid,
  input  logic                out_ready,
  output iss_pkg::status_t    scan_status,
  output iss_pkg::word_t      branch_target
);
  import iss_pkg::*;

  word_class_t cur_class;
  word_t       cur_target;

  // Window: flags of the two previous words (cleared = empty window).
  logic        older_stw;
  logic        newer_li;
  logic [1:0]  match_count;
  logic        link_found;
  word_t       found_target;

  // The older slot needs the store-word flag of the word now in the newer
  // slot, so that flag is tracked alongside newer_li.
  logic        newer_is_stw_q;

  logic        in_xact;
  logic        match_now;
  logic        link_take;
  logic [1:0]  match_count_next;
  logic        link_found_next;
  word_t       found_target_next;
  status_t     status_next;
  word_t       target_next;

  iss_decode u_decode (
    .word_address     (word_address),
    .instruction_word (instruction_word),
    .word_class       (cur_class),
    .link_target      (cur_target)
  );

  // Output register is free unless a result is stalled downstream.
  assign in_ready = !out_valid || out_ready;
  assign in_xact  = in_valid && in_ready;

  // Branch search uses the match count from before this word.
  assign link_take = (match_count != 2'd0) && !link_found && cur_class.is_bl;
  assign match_now = older_stw && newer_li && cur_class.is_stb;

  always_comb begin
    match_count_next = match_count;
    if (match_now && (match_count != 2'd2)) begin
      match_count_next = match_count + 2'd1;
    end
    link_found_next   = link_found || link_take;
    found_target_next = link_take ? cur_target : found_target;

    target_next = '0;
    priority if (match_count_next == 2'd2) begin
      status_next = STATUS_SEVERAL;
    end else if (match_count_next == 2'd0) begin
      status_next = STATUS_NONE;
    end else if (!link_found_next) begin
      status_next = STATUS_NO_LINK;
    end else begin
      status_next = STATUS_FOUND;
      target_next = found_target_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      older_stw    <= 1'b0;
      newer_li     <= 1'b0;
      match_count  <= 2'd0;
      link_found   <= 1'b0;
      found_target <= '0;
      out_valid    <= 1'b0;
    end else begin
      // a new result may replace one drained in the same cycle
      if (in_xact && last_word) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (in_xact) begin
        if (last_word) begin
          // close region: publish result, clear scan state
          older_stw     <= 1'b0;
          newer_li      <= 1'b0;
          match_count   <= 2'd0;
          link_found    <= 1'b0;
          found_target  <= '0;
          scan_status   <= status_next;
          branch_target <= target_next;
        end else begin
          older_stw    <= newer_is_stw_q;
          newer_li     <= cur_class.is_li;
          match_count  <= match_count_next;
          link_found   <= link_found_next;
          found_target <= found_target_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      newer_is_stw_q <= 1'b0;
    end else if (in_xact) begin
      newer_is_stw_q <= last_word ? 1'b0 : cur_class.is_stw;
    end
  end

endmodule

[design/iss_checker.sv]
// ----------------------------------------------------------------------------
// iss_checker
// Port-level checks of the signature scanner, bound to the top level.
// ----------------------------------------------------------------------------
module iss_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             last_word,
  input logic             out_valid,
  input logic             out_ready,
  input iss_pkg::status_t scan_status,
  input iss_pkg::word_t   branch_target
);
  import iss_pkg::*;

  // Stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(scan_status)
                                && $stable(branch_target))
    else $error("result changed while stalled");

  // Target is only reported with a found status.
  a_target_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (scan_status != STATUS_FOUND) |-> branch_target == '0)
    else $error("nonzero target without found status");

  // Last word yields a result on the next cycle.
  a_last_result: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && last_word |=> out_valid)
    else $error("no result after last word");

  // Non-last words never yield a result.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && !last_word |=> !out_valid)
    else $error("result without last word");

  // Input stalls only behind a waiting result.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without pending result");

endmodule

bind instruction_signature_scanner iss_checker u_iss_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .last_word     (last_word),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .scan_status   (scan_status),
  .branch_target (branch_target)
);
